// ===== rtl/qvs_pkg.sv =====
// Package for the quaternion vertex skinning unit: widths, opcodes, entry type.
// No dependencies.
package qvs_pkg;
	localparam int JointCount = 256;
	localparam int JointIdxW = $clog2(JointCount);
	localparam int FracBits = 16;
	localparam int AccW = 48;

	typedef enum logic {OP_LOAD = 1'b0, OP_WEIGHT = 1'b1} opcode_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} joint_t;

	typedef struct packed {
		logic [0:0] opcode;
		logic [7:0] joint_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic [16:0] bias;
		logic [0:0] last_weight;
	} item_t;

	typedef struct packed {
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
		logic [0:0] saturated;
	} result_t;
endpackage

// ===== rtl/qvs_item_if.sv =====
// Valid/ready channel for input items.
// Depends on qvs_pkg.
interface qvs_item_if
	import qvs_pkg::*;
();
	logic valid;
	logic ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/qvs_result_if.sv =====
// Valid/ready channel for result items.
// Depends on qvs_pkg.
interface qvs_result_if
	import qvs_pkg::*;
();
	logic valid;
	logic ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/quaternion_weighted_vertex_skinning_unit.sv =====
// Quaternion vertex skinning unit: joint table memory, rotation, blend, accumulate.
// Depends on qvs_pkg and the qvs_item_if / qvs_result_if channels.
// One item is in flight at a time; the serial multiply sequence sets the rate. A load
// writes the joint table on acceptance and the unit stays ready. A weight reads the
// table, forms the quaternion products serially, rounds the matrix, takes three dot
// products, then accumulates; a last weight emits once the previous result is taken.
// Reset clears control and accumulators; the joint table is undefined until written.
module quaternion_weighted_vertex_skinning_unit
	import qvs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	qvs_item_if.sink in_item,
	qvs_result_if.source out_result
);
	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_QP, S_MAT, S_RND, S_DOT, S_DRND, S_BIAS, S_ACC, S_WAIT
	} state_t;

	state_t state_q;
	joint_t mem [JointCount];
	joint_t ent_q;
	item_t it_q;
	logic oor_q;
	// Quaternion products: xx yy zz ww xy xz yz wx wy wz.
	logic signed [31:0] qp_q [10];
	logic signed [35:0] mr_q [9];
	logic [3:0] cnt_q;
	logic [1:0] row_q;
	logic signed [71:0] dot_q;
	logic signed [37:0] r_q [3];
	logic signed [AccW-1:0] acc_q [3];
	logic clip_q;
	logic out_valid_q;
	result_t out_q;

	// Product select for the quaternion stage.
	logic signed [15:0] pa, pb;
	always_comb begin
		unique case (cnt_q)
			4'd0: begin pa = ent_q.quat_x; pb = ent_q.quat_x; end
			4'd1: begin pa = ent_q.quat_y; pb = ent_q.quat_y; end
			4'd2: begin pa = ent_q.quat_z; pb = ent_q.quat_z; end
			4'd3: begin pa = ent_q.quat_w; pb = ent_q.quat_w; end
			4'd4: begin pa = ent_q.quat_x; pb = ent_q.quat_y; end
			4'd5: begin pa = ent_q.quat_x; pb = ent_q.quat_z; end
			4'd6: begin pa = ent_q.quat_y; pb = ent_q.quat_z; end
			4'd7: begin pa = ent_q.quat_w; pb = ent_q.quat_x; end
			4'd8: begin pa = ent_q.quat_w; pb = ent_q.quat_y; end
			default: begin pa = ent_q.quat_w; pb = ent_q.quat_z; end
		endcase
	end

	// Rotation matrix entries from the products, Q4.28 widened.
	logic signed [35:0] m [9];
	always_comb begin
		m[0] = 36'(qp_q[3]) + 36'(qp_q[0]) - 36'(qp_q[1]) - 36'(qp_q[2]);
		m[1] = (36'(qp_q[4]) - 36'(qp_q[9])) <<< 1;
		m[2] = (36'(qp_q[5]) + 36'(qp_q[8])) <<< 1;
		m[3] = (36'(qp_q[4]) + 36'(qp_q[9])) <<< 1;
		m[4] = 36'(qp_q[3]) - 36'(qp_q[0]) + 36'(qp_q[1]) - 36'(qp_q[2]);
		m[5] = (36'(qp_q[6]) - 36'(qp_q[7])) <<< 1;
		m[6] = (36'(qp_q[5]) - 36'(qp_q[8])) <<< 1;
		m[7] = (36'(qp_q[6]) + 36'(qp_q[7])) <<< 1;
		m[8] = 36'(qp_q[3]) - 36'(qp_q[0]) - 36'(qp_q[1]) + 36'(qp_q[2]);
	end

	// Dot product operand: rounded matrix entry times offset component.
	logic signed [31:0] ma;
	logic signed [31:0] vb;
	logic signed [63:0] dprod;
	always_comb begin
		ma = 32'(mr_q[4'(row_q) * 4'd3 + cnt_q]);
		unique case (cnt_q[1:0])
			2'd0: vb = it_q.pos_x;
			2'd1: vb = it_q.pos_y;
			default: vb = it_q.pos_z;
		endcase
		dprod = ma * vb;
	end

	// Blend: (rotated + joint position) times bias, rounded, then accumulate.
	logic signed [38:0] sum_sel;
	logic signed [55:0] bprod;
	logic signed [AccW+1:0] addend, acc_sum;
	always_comb begin
		unique case (row_q)
			2'd0: sum_sel = 39'(r_q[0]) + 39'(ent_q.pos_x);
			2'd1: sum_sel = 39'(r_q[1]) + 39'(ent_q.pos_y);
			default: sum_sel = 39'(r_q[2]) + 39'(ent_q.pos_z);
		endcase
		bprod = 56'(sum_sel) * $signed({1'b0, it_q.bias});
		addend = 50'((bprod + 56'(1 <<< (FracBits - 1))) >>> FracBits);
		acc_sum = 50'(acc_q[row_q]) + addend;
	end

	// Saturate accumulators to 32 bits on emit.
	function automatic logic [32:0] sat32(input logic signed [AccW-1:0] a);
		if (a > 48'sh7FFFFFFF) return {1'b1, 32'h7FFFFFFF};
		if (a < -48'sh80000000) return {1'b1, 32'h80000000};
		return {1'b0, a[31:0]};
	endfunction

	logic [32:0] sx, sy, sz;
	assign sx = sat32(acc_q[0]);
	assign sy = sat32(acc_q[1]);
	assign sz = sat32(acc_q[2]);

	assign in_item.ready = (state_q == S_IDLE);
	assign out_result.valid = out_valid_q;
	assign out_result.data = out_q;

	// Joint table memory: written by loads, read in the cycle after weight acceptance.
	always_ff @(posedge clk) begin
		if (in_item.valid && in_item.ready) begin
			if (in_item.data.opcode == OP_LOAD) begin
				mem[in_item.data.joint_index[JointIdxW-1:0]] <= '{
					in_item.data.pos_x, in_item.data.pos_y, in_item.data.pos_z,
					in_item.data.quat_x, in_item.data.quat_y, in_item.data.quat_z,
					in_item.data.quat_w};
			end
		end
		if (state_q == S_READ) begin
			ent_q <= oor_q ? '0 : mem[it_q.joint_index[JointIdxW-1:0]];
		end
	end

	// Sequencer for one weight item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			row_q <= '0;
			clip_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) acc_q[i] <= '0;
		end else begin
			if (out_valid_q && out_result.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_item.valid && in_item.ready
							&& in_item.data.opcode == OP_WEIGHT) begin
						it_q <= in_item.data;
						oor_q <= 1'b0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					cnt_q <= '0;
					state_q <= S_QP;
				end
				S_QP: begin
					qp_q[cnt_q] <= pa * pb;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd9) state_q <= S_MAT;
				end
				S_MAT: begin
					for (int i = 0; i < 9; i++) mr_q[i] <= m[i];
					state_q <= S_RND;
				end
				S_RND: begin
					for (int i = 0; i < 9; i++)
						mr_q[i] <= (mr_q[i] + 36'sd8) >>> 4;
					cnt_q <= '0;
					row_q <= '0;
					dot_q <= '0;
					state_q <= S_DOT;
				end
				S_DOT: begin
					dot_q <= dot_q + 72'(dprod);
					if (cnt_q == 4'd2) begin
						cnt_q <= '0;
						state_q <= S_DRND;
					end else cnt_q <= cnt_q + 4'd1;
				end
				S_DRND: begin
					r_q[row_q] <= 38'((dot_q + 72'sd8388608) >>> 24);
					dot_q <= '0;
					if (row_q == 2'd2) begin
						row_q <= '0;
						state_q <= S_BIAS;
					end else begin
						row_q <= row_q + 2'd1;
						state_q <= S_DOT;
					end
				end
				S_BIAS: begin
					if (acc_sum > 50'sh7FFFFFFFFFFF) begin
						acc_q[row_q] <= 48'sh7FFFFFFFFFFF;
						clip_q <= 1'b1;
					end else if (acc_sum < -50'sh800000000000) begin
						acc_q[row_q] <= 48'sh800000000000;
						clip_q <= 1'b1;
					end else acc_q[row_q] <= acc_sum[AccW-1:0];
					if (row_q == 2'd2) state_q <= S_ACC;
					else row_q <= row_q + 2'd1;
				end
				S_ACC: begin
					if (it_q.last_weight == 1'b1) state_q <= S_WAIT;
					else state_q <= S_IDLE;
				end
				S_WAIT: begin
					if (!out_valid_q) begin
						out_q <= '{sx[31:0], sy[31:0], sz[31:0],
							clip_q | sx[32] | sy[32] | sz[32]};
						out_valid_q <= 1'b1;
						for (int i = 0; i < 3; i++) acc_q[i] <= '0;
						clip_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
